[rtl/core/sdtw_pkg.sv]
// Shared types, constants and factor table for the soft-DTW forward block.
package sdtw_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 48;
    localparam int COST_W    = 32;
    localparam int CNT_W     = 11;
    localparam int GAMMA_W   = 24;
    localparam int BAND_W    = 12;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VAL_W-1:0] VAL_INF = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] ONE_Q30   = 31'd1073741824;

    // Register indexes on the configuration port.
    localparam logic REG_GAMMA = 1'b0;
    localparam logic REG_BAND  = 1'b1;

    typedef struct packed {
        logic signed [COST_W-1:0] cell_cost;
        logic [CNT_W-1:0]         row_count;
        logic [CNT_W-1:0]         col_count;
        logic                     first_cell;
    } t_sdtw_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] acc_cost;
        logic                    unreachable;
        logic                    last_cell;
    } t_sdtw_out;

    // One classified cell as it travels from the front to the back.
    typedef struct packed {
        logic signed [COST_W-1:0] cost;
        logic [CNT_W-1:0]         col;
        logic                     row_zero;
        logic                     col_zero;
        logic                     in_band;
        logic                     last;
    } t_sdtw_desc;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

    // 2^(-2^-(j+1)) in Q30.
    function automatic logic [29:0] pow_factor(input logic [3:0] j);
        logic [29:0] f;
        case (j)
            4'd0:    f = 30'd759250125;
            4'd1:    f = 30'd902905651;
            4'd2:    f = 30'd984625594;
            4'd3:    f = 30'd1028218693;
            4'd4:    f = 30'd1050733751;
            4'd5:    f = 30'd1062175491;
            4'd6:    f = 30'd1067932888;
            4'd7:    f = 30'd1070838486;
            4'd8:    f = 30'd1072289171;
            4'd9:    f = 30'd1073015252;
            4'd10:   f = 30'd1073378476;
            4'd11:   f = 30'd1073560135;
            default: f = 30'd0;
        endcase
        return f;
    endfunction

endpackage

[rtl/core/sdtw_fifo.sv]
// Short queue of classified cells between the front and the back.
module sdtw_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sdtw_pkg::t_sdtw_desc i_push_data,
    input  logic                 i_pop,
    output sdtw_pkg::t_sdtw_desc o_head,
    output sdtw_pkg::t_queue_stat o_stat
);
    import sdtw_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_sdtw_desc     r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [PW:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head     = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (PW+1)'(QUEUE_DEPTH));

endmodule

[rtl/core/sdtw_front.sv]
// Front end: takes cells, tracks grid position and band, queues descriptors.
module sdtw_front #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sdtw_pkg::t_sdtw_in            i_in_data,
    input  logic [sdtw_pkg::BAND_W-1:0]   i_band_width,
    input  logic                          i_q_full,
    output logic                          o_push,
    output sdtw_pkg::t_sdtw_desc          o_push_data
);
    import sdtw_pkg::*;

    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] ROW_LIM =
        (MAX_ROWS > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_ROWS);
    localparam logic [CNT_W-1:0] COL_LIM =
        (MAX_COLS > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_COLS);

    logic [CNT_W-1:0] r_row_pos, r_col_pos, r_rows, r_cols;
    logic [CNT_W-1:0] n_row_pos, n_col_pos, n_rows, n_cols;
    logic [CNT_W-1:0] w_rc, w_cc, w_r, w_c, w_dist;
    logic             w_start, w_accept, w_row_end, w_col_end;

    assign w_accept   = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign w_start    = i_in_data.first_cell || (r_rows == '0);

    always_comb begin
        w_rc = i_in_data.row_count;
        if (w_rc == '0) w_rc = CNT_W'(1);
        else if (w_rc > ROW_LIM) w_rc = ROW_LIM;
        w_cc = i_in_data.col_count;
        if (w_cc == '0) w_cc = CNT_W'(1);
        else if (w_cc > COL_LIM) w_cc = COL_LIM;

        n_rows = w_start ? w_rc : r_rows;
        n_cols = w_start ? w_cc : r_cols;
        w_r    = w_start ? '0 : r_row_pos;
        w_c    = w_start ? '0 : r_col_pos;
        w_dist = (w_r >= w_c) ? (w_r - w_c) : (w_c - w_r);

        w_row_end = (w_r == n_rows - 1'b1);
        w_col_end = (w_c == n_cols - 1'b1);
        if (w_col_end) begin
            n_col_pos = '0;
            n_row_pos = w_row_end ? '0 : w_r + 1'b1;
        end else begin
            n_col_pos = w_c + 1'b1;
            n_row_pos = w_r;
        end

        o_push_data.cost     = i_in_data.cell_cost;
        o_push_data.col      = w_c;
        o_push_data.row_zero = (w_r == '0);
        o_push_data.col_zero = (w_c == '0);
        o_push_data.in_band  = i_band_width[BAND_W-1] ||
                               ({1'b0, w_dist} <= i_band_width);
        o_push_data.last     = w_row_end && w_col_end;
    end

    assign o_push = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
            r_rows    <= '0;
            r_cols    <= '0;
        end else if (w_accept) begin
            r_row_pos <= n_row_pos;
            r_col_pos <= n_col_pos;
            r_rows    <= n_rows;
            r_cols    <= n_cols;
        end
    end

endmodule

[rtl/core/sdtw_softmin.sv]
// Serial soft-minimum of three values with table-based exp and log.
module sdtw_softmin (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [sdtw_pkg::VAL_W-1:0]   i_a,
    input  logic signed [sdtw_pkg::VAL_W-1:0]   i_b,
    input  logic signed [sdtw_pkg::VAL_W-1:0]   i_c,
    input  logic [sdtw_pkg::GAMMA_W-1:0]        i_gamma,
    output logic                                o_done,
    output logic signed [sdtw_pkg::VAL_W-1:0]   o_result
);
    import sdtw_pkg::*;

    localparam int QW  = FRAC_BITS + 5;      // quotient bits, since d < 32*gamma
    localparam int UW  = QW + 1;             // t * log2(e) grows one bit
    localparam int NW  = UW - FRAC_BITS;
    localparam int SW  = FRAC_BITS + 3;      // sum of three terms up to one each
    localparam int LW  = FRAC_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SEL, S_DIV, S_LOG2E, S_POW, S_ACC,
        S_LNINIT, S_LN, S_LNMUL, S_SCALE, S_RES
    } t_state;

    t_state                   r_state;
    logic signed [VAL_W-1:0]  r_v [3];
    logic signed [VAL_W-1:0]  r_mn, r_res;
    logic [GAMMA_W-1:0]       r_g;
    logic [1:0]               r_k;
    logic [GAMMA_W-1:0]       r_rem;
    logic [QW-1:0]            r_dvd, r_q;
    logic [4:0]               r_cnt;
    logic [UW-1:0]            r_u;
    logic [30:0]              r_m, r_x;
    logic [3:0]               r_j;
    logic [SW-1:0]            r_sum;
    logic [12:0]              r_lg;
    logic [LW-1:0]            r_ln;
    logic [GAMMA_W:0]         r_p;
    logic                     r_done;

    logic signed [VAL_W-1:0]  w_min, w_v;
    logic [VAL_W-1:0]         w_d;
    logic                     w_skip, w_ge, w_bit;
    logic [GAMMA_W:0]         w_trial, w_diff;
    logic [52:0]              w_uprod;
    logic [60:0]              w_mprod, w_xprod;
    logic [29:0]              w_pow;
    logic [11:0]              w_f12;
    logic [NW-1:0]            w_n;
    logic [6:0]               w_shamt;
    logic [30:0]              w_term;
    logic [32:0]              w_x0;
    logic [42:0]              w_lnprod;
    logic [GAMMA_W+LW-1:0]    w_pprod;
    logic signed [VAL_W:0]    w_res;

    always_comb begin
        w_min = i_a;
        if (i_b < w_min) w_min = i_b;
        if (i_c < w_min) w_min = i_c;

        w_v    = r_v[r_k];
        w_d    = w_v - r_mn;
        w_skip = (w_v == VAL_INF) || (w_d >= {{(VAL_W-GAMMA_W-5){1'b0}}, r_g, 5'b0});

        w_trial = {r_rem, r_dvd[QW-1]};
        w_ge    = (w_trial >= {1'b0, r_g});
        w_diff  = w_trial - {1'b0, r_g};

        w_uprod = 53'(r_q) * 53'(LOG2E_Q30);
        w_pow   = pow_factor(r_j);
        w_f12   = r_u[FRAC_BITS-1 -: 12];
        w_bit   = w_f12[4'd11 - r_j];
        w_mprod = 61'(r_m) * 61'(w_pow);
        w_xprod = 61'(r_x) * 61'(w_pow);

        w_n     = r_u[UW-1:FRAC_BITS];
        w_shamt = 7'(30 - FRAC_BITS) + 7'(w_n);
        w_term  = (w_n > NW'(FRAC_BITS + 1)) ? '0 : (r_m >> w_shamt);

        w_x0     = 33'(r_sum) << (30 - FRAC_BITS);
        w_lnprod = 43'(r_lg) * 43'(LN2_Q30);
        w_pprod  = (GAMMA_W+LW)'(r_g) * (GAMMA_W+LW)'(r_ln);
        w_res    = {r_mn[VAL_W-1], r_mn} - {{(VAL_W-GAMMA_W){1'b0}}, r_p};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            // Done pulses when all inputs are infinite or the result is formed.
            r_done <= ((r_state == S_IDLE) && i_start && (w_min == VAL_INF)) ||
                      (r_state == S_RES);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_v[0] <= i_a;
                        r_v[1] <= i_b;
                        r_v[2] <= i_c;
                        r_g    <= (i_gamma == '0) ? GAMMA_W'(1) : i_gamma;
                        r_mn   <= w_min;
                        r_sum  <= '0;
                        r_k    <= '0;
                        if (w_min == VAL_INF) begin
                            r_res  <= VAL_INF;
                        end else begin
                            r_state <= S_SEL;
                        end
                    end
                end
                S_SEL: begin
                    if (w_skip) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= (r_k == 2'd2) ? S_LNINIT : S_SEL;
                    end else begin
                        r_rem   <= w_d[GAMMA_W+4:5];
                        r_dvd   <= {w_d[4:0], {FRAC_BITS{1'b0}}};
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_diff[GAMMA_W-1:0] : w_trial[GAMMA_W-1:0];
                    r_dvd <= r_dvd << 1;
                    r_q   <= {r_q[QW-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(QW - 1)) r_state <= S_LOG2E;
                end
                S_LOG2E: begin
                    r_u     <= w_uprod[30 +: UW];
                    r_m     <= ONE_Q30;
                    r_j     <= '0;
                    r_state <= S_POW;
                end
                S_POW: begin
                    if (w_bit) r_m <= w_mprod[60:30];
                    r_j <= r_j + 1'b1;
                    if (r_j == 4'd11) r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum   <= r_sum + w_term[SW-1:0];
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k == 2'd2) ? S_LNINIT : S_SEL;
                end
                S_LNINIT: begin
                    if (w_x0 >= 33'(2 * 64'(ONE_Q30))) begin
                        r_x  <= w_x0[31:1];
                        r_lg <= 13'h1000;
                    end else begin
                        r_x  <= w_x0[30:0];
                        r_lg <= '0;
                    end
                    r_j     <= '0;
                    r_state <= S_LN;
                end
                S_LN: begin
                    if (w_xprod[60:30] >= ONE_Q30) begin
                        r_x <= w_xprod[60:30];
                        r_lg[4'd11 - r_j] <= 1'b1;
                    end
                    r_j <= r_j + 1'b1;
                    if (r_j == 4'd11) r_state <= S_LNMUL;
                end
                S_LNMUL: begin
                    r_ln    <= w_lnprod[(42-FRAC_BITS) +: LW];
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_p     <= w_pprod[FRAC_BITS +: (GAMMA_W+1)];
                    r_state <= S_RES;
                end
                S_RES: begin
                    r_res   <= (w_res < $signed({VAL_NEG[VAL_W-1], VAL_NEG}))
                               ? VAL_NEG : w_res[VAL_W-1:0];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

[rtl/core/sdtw_back.sv]
// Back end: neighbor values, row memory, soft-min and output register.
module sdtw_back #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sdtw_pkg::t_sdtw_desc          i_head,
    input  sdtw_pkg::t_queue_stat         i_q_stat,
    output logic                          o_pop,
    input  logic [sdtw_pkg::GAMMA_W-1:0]  i_gamma,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sdtw_pkg::t_sdtw_out           o_out_data
);
    import sdtw_pkg::*;

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [1:0] {B_IDLE, B_START, B_WAIT, B_FIN} t_state;

    t_state                   r_state;
    t_sdtw_desc               r_desc;
    logic signed [VAL_W-1:0]  r_mem [MEM_DEPTH];
    logic signed [VAL_W-1:0]  r_rd, r_left, r_diag, r_up, r_val;
    logic                     r_out_valid;
    t_sdtw_out                r_out;

    logic signed [VAL_W-1:0]  w_up, w_left, w_diag, w_sm;
    logic signed [VAL_W:0]    w_sum;
    logic                     w_sm_start, w_sm_done, w_out_free, w_fin;

    always_comb begin
        w_up   = r_desc.row_zero ? VAL_INF : r_rd;
        w_left = r_desc.col_zero ? VAL_INF : r_left;
        if (r_desc.row_zero && r_desc.col_zero) w_diag = '0;
        else if (r_desc.row_zero || r_desc.col_zero) w_diag = VAL_INF;
        else w_diag = r_diag;
        w_sum = {{(VAL_W+1-COST_W){r_desc.cost[COST_W-1]}}, r_desc.cost} +
                {w_sm[VAL_W-1], w_sm};
    end

    assign o_pop      = (r_state == B_IDLE) && !i_q_stat.empty;
    assign w_sm_start = (r_state == B_START) && r_desc.in_band;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fin      = (r_state == B_FIN) && w_out_free;

    sdtw_softmin u_softmin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_sm_start),
        .i_a      (w_diag),
        .i_b      (w_up),
        .i_c      (w_left),
        .i_gamma  (i_gamma),
        .o_done   (w_sm_done),
        .o_result (w_sm)
    );

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_mem[i_head.col[AW-1:0]];
        end
        if (w_fin) begin
            r_mem[r_desc.col[AW-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= VAL_INF;
            r_diag      <= VAL_INF;
        end else begin
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_desc  <= i_head;
                        r_state <= B_START;
                    end
                end
                B_START: begin
                    r_up <= w_up;
                    if (r_desc.in_band) begin
                        r_state <= B_WAIT;
                    end else begin
                        r_val   <= VAL_INF;
                        r_state <= B_FIN;
                    end
                end
                B_WAIT: begin
                    if (w_sm_done) begin
                        if (w_sm == VAL_INF || w_sum >= $signed({1'b0, VAL_INF})) begin
                            r_val <= VAL_INF;
                        end else if (w_sum < $signed({1'b1, VAL_NEG})) begin
                            r_val <= VAL_NEG;
                        end else begin
                            r_val <= w_sum[VAL_W-1:0];
                        end
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    if (w_out_free) begin
                        r_out.acc_cost    <= r_val;
                        r_out.unreachable <= (r_val == VAL_INF);
                        r_out.last_cell   <= r_desc.last;
                        r_left            <= r_val;
                        r_diag            <= r_up;
                        r_state           <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/core/soft_dtw_forward.sv]
// Top level of the soft-DTW forward recurrence with configuration registers.
//
// Cost-matrix cells enter one beat at a time in row-major order; a beat with
// first_cell set (or the first beat after reset) latches the grid size,
// clamped to [1, MAX_ROWS] by [1, MAX_COLS]. Each accepted cell yields
// exactly one result beat holding R = cost + softmin_gamma(up-left, up, left)
// in signed Q32.16, with the all-ones positive code standing for infinity and
// unreachable raised alongside it. Cells outside the Sakoe-Chiba band (when
// band_width is non-negative) come out infinite. last_cell marks the final
// cell, whose value is the distance; after it the grid wraps to the origin
// with the same size. The front end classifies cells and queues up to two
// of them, so the input keeps moving while the back end works until the
// queue is full. The back end handles one cell at a time: a cell outside
// the band skips the soft-min, and a cell in the band whose neighbors are
// all infinite skips the exp/log steps. For any other cell the time is set
// by the single serial exp/log unit, which runs a one-bit-per-cycle divider
// and twelve table multiplies for each finite neighbor within 32*gamma of
// the minimum, then twelve multiplies for the logarithm. The output register
// lets a finished result wait for the consumer while the next cell is
// computed.
// gamma and band_width sit on an APB-style port at byte addresses 0 and 4
// and may only be changed while the block is idle.
module soft_dtw_forward #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sdtw_pkg::t_sdtw_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sdtw_pkg::t_sdtw_out  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import sdtw_pkg::*;

    // The row memory only needs one entry per column that can be addressed.
    localparam int MEM_DEPTH = (MAX_COLS < 2047) ? MAX_COLS : 2047;

    logic [GAMMA_W-1:0] r_gamma;
    logic [BAND_W-1:0]  r_band_width;
    logic               w_cfg_wr;

    logic               w_push, w_pop;
    t_sdtw_desc         w_push_data, w_head;
    t_queue_stat        w_q_stat;

    // Configuration registers. Writes complete in the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma      <= GAMMA_W'(65536);
            r_band_width <= '1;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_GAMMA: r_gamma      <= pwdata[GAMMA_W-1:0];
                REG_BAND:  r_band_width <= pwdata[BAND_W-1:0];
                default:   r_gamma      <= r_gamma;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GAMMA: prdata = {{(32-GAMMA_W){1'b0}}, r_gamma};
            REG_BAND:  prdata = {{(32-BAND_W){1'b0}}, r_band_width};
            default:   prdata = '0;
        endcase
    end

    // Front end: position tracking, band check and first-cell handling.
    sdtw_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_band_width (r_band_width),
        .i_q_full     (w_q_stat.full),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    // Queue decoupling the two halves.
    sdtw_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_q_stat)
    );

    // Back end: the recurrence itself.
    sdtw_back #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .i_gamma     (r_gamma),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // The infinity code and the unreachable flag always travel together.
    a_inf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.unreachable == (o_out_data.acc_cost == VAL_INF)))
        else $error("unreachable flag disagrees with acc_cost");

    // The queue is never written while full nor read while empty.
    a_q_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_stat.full) && !(w_pop && w_q_stat.empty))
        else $error("queue overflow or underflow");

    // No result appears in the cycle after reset.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

[tb/soft_dtw_forward_tb.sv]
// Self-checking testbench for the soft-DTW forward recurrence block.
`timescale 1ns / 1ps

module soft_dtw_forward_tb;
    import sdtw_pkg::*;

    // The infinity code and the negative clamp, held as 64-bit signed numbers.
    localparam longint COST_INF = 64'sd140737488355327;
    localparam longint COST_NEG = -64'sd140737488355328;
    localparam longint unsigned LOG2E = 64'd1549082005;
    localparam longint unsigned LN2 = 64'd744261118;
    localparam longint unsigned UNIT_Q30 = 64'd1073741824;
    localparam int GRID_MAX = 1024;
    localparam int SETTLE_CYCLES = 600;
    localparam int CYCLE_LIMIT = 2500000;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_GAMMA = 3'd0;
    localparam logic [2:0] ADDR_BAND  = 3'd4;

    // Q30 factors 2^(-2^-(j+1)) used by both the exp and the log steps.
    localparam longint unsigned HALVING_POW [12] = '{
        64'd759250125, 64'd902905651, 64'd984625594, 64'd1028218693,
        64'd1050733751, 64'd1062175491, 64'd1067932888, 64'd1070838486,
        64'd1072289171, 64'd1073015252, 64'd1073378476, 64'd1073560135
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_sdtw_in    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_sdtw_out   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    soft_dtw_forward dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Predictor state: our own copy of the registers and the recurrence memory.
    logic [GAMMA_W-1:0]        gamma_reg;
    logic signed [BAND_W-1:0]  band_reg;
    longint                    row_above [GRID_MAX + 1];
    longint                    left_acc;
    longint                    diag_acc;
    int                        cur_row;
    int                        cur_col;
    int                        grid_rows;
    int                        grid_cols;

    // Expected result beats, oldest first.
    t_sdtw_out expected_acc [$];

    int  mismatch_count;
    int  cells_sent;
    int  results_seen;
    int  finite_seen;
    int  band_hits;
    int  cycle_count;
    bit  quiet_sender;
    bit  quiet_receiver;
    bit  pressure_req;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Runaway guard. The limit allows for each cell's time in the serial back
    // end plus the consumer's stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
    endtask

    // ------------------------------------------------------------------
    // Fixed-point predictor.
    // ------------------------------------------------------------------

    // exp(-d/g) in Q.16 for d >= 0, using the halving-power table.
    function automatic longint unsigned exp_weight(input longint unsigned d,
                                                   input longint unsigned g);
        longint unsigned t, u, n, f12, m;
        if (d >= 32 * g) return 0;
        t = (d << FRAC_BITS) / g;
        u = (t * LOG2E) >> 30;
        n = u >> FRAC_BITS;
        if (n > FRAC_BITS + 1) return 0;
        f12 = ((u & 64'hFFFF) << 12) >> FRAC_BITS;
        m = UNIT_Q30;
        for (int j = 0; j < 12; j++)
            if (f12[11 - j]) m = (m * HALVING_POW[j]) >> 30;
        return m >> (30 - FRAC_BITS + n);
    endfunction

    // ln(s) in Q.16 for s in Q.16 within [1,4).
    function automatic longint unsigned log_weight(input longint unsigned s);
        longint unsigned x, y, lg;
        x = s << (30 - FRAC_BITS);
        lg = 0;
        if (x >= 2 * UNIT_Q30) begin
            x = x >> 1;
            lg = 1 << 12;
        end
        for (int j = 0; j < 12; j++) begin
            y = (x * HALVING_POW[j]) >> 30;
            if (y >= UNIT_Q30) begin
                x = y;
                lg = lg | (64'd1 << (11 - j));
            end
        end
        return (lg * LN2) >> (42 - FRAC_BITS);
    endfunction

    function automatic longint smooth_min(input longint a, input longint b, input longint c);
        longint vals [3];
        longint lo, res;
        longint unsigned sum, g;
        g = (gamma_reg == 0) ? 64'd1 : 64'(gamma_reg);
        vals = '{a, b, c};
        lo = a;
        if (b < lo) lo = b;
        if (c < lo) lo = c;
        if (lo >= COST_INF) return COST_INF;
        sum = 0;
        foreach (vals[k])
            if (vals[k] < COST_INF) sum += exp_weight(longint'(vals[k] - lo), g);
        res = lo - longint'((g * log_weight(sum)) >> FRAC_BITS);
        return (res < COST_NEG) ? COST_NEG : res;
    endfunction

    // Advances the predictor by one accepted cell and queues its result.
    function automatic void predict_cell(input t_sdtw_in in_beat);
        longint up, lft, dg, acc, sm, gap;
        int r, c;
        bit in_band;
        t_sdtw_out res;
        if (in_beat.first_cell || grid_rows == 0) begin
            grid_rows = (in_beat.row_count < 1) ? 1 :
                        (in_beat.row_count > GRID_MAX) ? GRID_MAX : int'(in_beat.row_count);
            grid_cols = (in_beat.col_count < 1) ? 1 :
                        (in_beat.col_count > GRID_MAX) ? GRID_MAX : int'(in_beat.col_count);
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        up  = (r == 0) ? COST_INF : row_above[c];
        lft = (c == 0) ? COST_INF : left_acc;
        if (r == 0 && c == 0) dg = 0;
        else if (r == 0 || c == 0) dg = COST_INF;
        else dg = diag_acc;

        gap = longint'(r) - longint'(c);
        if (gap < 0) gap = -gap;
        in_band = (band_reg < 0) || (gap <= longint'(band_reg));

        acc = COST_INF;
        if (in_band) begin
            sm = smooth_min(dg, up, lft);
            if (sm < COST_INF) begin
                acc = longint'(in_beat.cell_cost) + sm;
                if (acc >= COST_INF) acc = COST_INF;
                else if (acc < COST_NEG) acc = COST_NEG;
            end
        end else begin
            band_hits++;
        end

        diag_acc = up;
        left_acc = acc;
        row_above[c] = acc;

        res.acc_cost    = acc[VAL_W-1:0];
        res.unreachable = (acc >= COST_INF);
        res.last_cell   = (r + 1 == grid_rows) && (c + 1 == grid_cols);
        if (!res.unreachable) finite_seen++;
        expected_acc.push_back(res);

        c++;
        if (c >= grid_cols) begin
            c = 0;
            r++;
            if (r >= grid_rows) r = 0;
        end
        cur_row = r;
        cur_col = c;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result beat against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_acc.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                t_sdtw_out want;
                want = expected_acc.pop_front();
                if (o_out_data.acc_cost !== want.acc_cost)
                    report_mismatch("acc_cost", o_out_data.acc_cost, want.acc_cost);
                if (o_out_data.unreachable !== want.unreachable)
                    report_mismatch("unreachable", o_out_data.unreachable, want.unreachable);
                if (o_out_data.last_cell !== want.last_cell)
                    report_mismatch("last_cell", o_out_data.last_cell, want.last_cell);
            end
            results_seen++;
        end
    end

    // Consumer stall. Normally it stalls at random, about 29 percent of the time; on
    // request it holds off for a long, counted stretch so that the block's
    // internal queue fills and the input side has to stall.
    initial begin
        int hold_left;
        i_out_stall = 1'b1;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (pressure_req && hold_left == 0) begin
                hold_left = 400;
                pressure_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!i_rst_n) begin
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet_receiver && ($urandom_range(99) < 29);
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks.
    // ------------------------------------------------------------------

    // Offers one cell beat, waits until it is taken, then maybe idles a while.
    // The valid line is left high when no gap follows, so back-to-back beats
    // never see valid dropped and raised within one time step.
    task automatic send_cell(input logic signed [31:0] cost, input int rows,
                             input int cols, input bit first);
        t_sdtw_in in_beat;
        in_beat.cell_cost  = cost;
        in_beat.row_count  = rows[CNT_W-1:0];
        in_beat.col_count  = cols[CNT_W-1:0];
        in_beat.first_cell = first;
        i_in_valid <= 1'b1;
        i_in_data  <= in_beat;
        do @(posedge i_clk); while (o_in_stall);
        predict_cell(in_beat);
        cells_sent++;
        if (!quiet_sender && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Lowers valid and lets every expected result drain, plus the longest
    // back-end latency, so the block is idle.
    task automatic drain_all();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_acc.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB write: setup cycle, then access cycle; pready is always high.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        drain_all();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_GAMMA) gamma_reg = value[GAMMA_W-1:0];
        else band_reg = value[BAND_W-1:0];
    endtask

    task automatic send_pair(input int rows, input int cols, input int cost_lo,
                             input int cost_hi);
        for (int k = 0; k < rows * cols; k++)
            send_cell($urandom_range(cost_hi - cost_lo) + cost_lo, rows, cols, k == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A cell without first_cell right after reset must still open a pair;
    // after the last cell the grid wraps to the origin with the same size.
    task automatic test_start_and_wrap();
        send_cell(32'sh0001_0000, 2, 2, 1'b0);
        send_cell(32'sh0000_8000, 2, 2, 1'b0);
        send_cell(-32'sh0000_4000, 7, 9, 1'b0);
        send_cell(32'sh0002_0000, 2, 2, 1'b0);
        for (int k = 0; k < 4; k++) send_cell(32'sh0000_1000 * k, 2, 2, 1'b0);
    endtask

    // Cost and size extremes, including counts that clamp at both ends.
    task automatic test_field_extremes();
        send_cell(32'sh7FFF_FFFF, 1, 1, 1'b1);
        send_cell(32'sh8000_0000, 1, 1, 1'b1);
        send_cell(32'sh0000_0000, 0, 0, 1'b1);
        send_cell(32'shFFFF_FFFF, 2047, 2047, 1'b1);
        send_cell(32'sh5555_5555, 1024, 1024, 1'b1);
        send_cell(32'shAAAA_AAAA, 1, 3, 1'b1);
        send_cell(32'sh7FFF_FFFF, 1, 3, 1'b0);
        send_cell(32'sh8000_0000, 1, 3, 1'b0);
    endtask

    // Narrow and wide bands, and the two ends of the gamma range.
    task automatic test_band_and_gamma();
        write_reg(ADDR_BAND, 32'd0);
        send_pair(3, 3, 0, 32'h0003_0000);
        write_reg(ADDR_BAND, 32'd1024);
        write_reg(ADDR_GAMMA, 32'd1);
        send_pair(2, 2, 0, 32'h0001_0000);
        write_reg(ADDR_GAMMA, 32'hFF_FFFF);
        send_pair(2, 2, 0, 32'h0001_0000);
        write_reg(ADDR_BAND, 32'hFFF);
    endtask

    // Random pairs with random content; a small share of beats restart a
    // pair in the middle and some pairs are left unfinished.
    task automatic test_random_pairs(input int count);
        int stop_at, rows, cols, cells;
        logic [31:0] cost;
        stop_at = cells_sent + count;
        while (cells_sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                rows = $urandom_range(1, 24);
                cols = $urandom_range(1, 24);
            end else begin
                rows = $urandom_range(1, 6);
                cols = $urandom_range(1, 6);
            end
            cells = rows * cols;
            if ($urandom_range(9) == 0) cells = $urandom_range(1, cells);
            for (int k = 0; k < cells; k++) begin
                case ($urandom_range(9))
                    0, 1, 2: cost = $urandom();
                    3, 4:    cost = $urandom_range(32'h0004_0000);
                    default: cost = $urandom_range(32'h0006_0000) - 32'h0003_0000;
                endcase
                if (k != 0 && $urandom_range(24) == 0)
                    send_cell(cost, $urandom_range(1, 6), $urandom_range(1, 6), 1'b1);
                else
                    send_cell(cost, rows, cols, k == 0);
            end
        end
    endtask

    // The consumer holds off while the sender keeps offering cells.
    task automatic test_back_pressure();
        quiet_sender = 1'b1;
        pressure_req = 1'b1;
        send_pair(4, 5, 0, 32'h0002_0000);
        quiet_sender = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        cells_sent     = 0;
        results_seen   = 0;
        finite_seen    = 0;
        band_hits      = 0;
        cycle_count    = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        pressure_req   = 1'b0;
        gamma_reg      = 24'd65536;
        band_reg       = -12'sd1;
        left_acc       = COST_INF;
        diag_acc       = COST_INF;
        cur_row        = 0;
        cur_col        = 0;
        grid_rows      = 0;
        grid_cols      = 0;
        foreach (row_above[k]) row_above[k] = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_start_and_wrap();
        test_field_extremes();
        test_band_and_gamma();
        test_back_pressure();

        // Random phases over several register settings.
        test_random_pairs(260);
        write_reg(ADDR_GAMMA, 32'd1);
        write_reg(ADDR_BAND, 32'd1);
        quiet_sender = 1'b1;
        quiet_receiver = 1'b1;
        test_random_pairs(120);
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        test_random_pairs(140);
        write_reg(ADDR_GAMMA, 32'hFF_FFFF);
        write_reg(ADDR_BAND, 32'd0);
        test_random_pairs(260);
        write_reg(ADDR_GAMMA, $urandom_range(1, 32'h3_FFFF));
        write_reg(ADDR_BAND, $urandom_range(0, 3));
        test_random_pairs(260);

        drain_all();
        $display("Sent %0d cells and checked %0d results (%0d finite, %0d outside the band),",
                 cells_sent, results_seen, finite_seen, band_hits);
        $display("across several gamma and band settings, with back-pressure and restarts.");
        if (mismatch_count == 0 && expected_acc.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/sdtw_pkg.sv
rtl/core/sdtw_fifo.sv
rtl/core/sdtw_front.sv
rtl/core/sdtw_softmin.sv
rtl/core/sdtw_back.sv
rtl/core/soft_dtw_forward.sv
tb/soft_dtw_forward_tb.sv
